// ===== design/cns_pkg.sv =====
// ----------------------------------------------------------------------------
// cns_pkg
// Shared widths, register indexes, word types and helpers of the five-point
// stencil sum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cns_pkg;

  localparam int MAX_ROWS_DEF    = 1024;
  localparam int MAX_COLUMNS_DEF = 1024;

  localparam int CFG_W       = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 19;
  localparam int IDX_W       = 10;
  localparam int RES_N       = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = CFG_INDEX_W'(1);

  localparam logic [CFG_W-1:0] ROW_COUNT_RST    = CFG_W'(3);
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = CFG_W'(4);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [1:0]                 slot_t;

  typedef struct packed {
    sample_t sample;
  } grid_word_t;

  typedef struct packed {
    sum_t neighbour_sum;
    idx_t cell_row;
    idx_t cell_column;
    logic last_of_run;
  } result_word_t;

  typedef struct packed {
    sum_t sum;
    idx_t row;
    idx_t column;
  } cell_result_t;

  typedef struct packed {
    logic             load;
    logic [RES_N-1:0] mask;
  } run_t;

  typedef struct packed {
    logic release_up;
    logic has_up;
    logic last_row;
    logic has_left;
    logic has_left2;
    logic has_right;
    logic last_col;
  } step_flags_t;

  function automatic sum_t sext(sample_t s);
    return {{(SUM_W - SAMPLE_W){s[SAMPLE_W-1]}}, s};
  endfunction

  function automatic slot_t slot_back1(slot_t s);
    return (s == 2'd0) ? 2'd2 : slot_t'(s - 2'd1);
  endfunction

  function automatic slot_t slot_back2(slot_t s);
    return (s == 2'd0) ? 2'd1 : ((s == 2'd1) ? 2'd2 : 2'd0);
  endfunction

endpackage

// ===== design/cns_stream_if.sv =====
// ----------------------------------------------------------------------------
// cns_stream_if
// Valid/ready stream channel carrying one word of a given type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cns_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== design/cns_line_mem.sv =====
// ----------------------------------------------------------------------------
// cns_line_mem
// Three-row line store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cns_line_mem import cns_pkg::*; #(
  parameter int DEPTH = 3 * MAX_COLUMNS_DEF,
  parameter int AW    = $clog2(3 * MAX_COLUMNS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  sample_t       wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output sample_t       rdata0,
  output sample_t       rdata1
);

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== design/cns_result_buf.sv =====
// ----------------------------------------------------------------------------
// cns_result_buf
// Holds the up to three results of one sample and sends them one word at a
// time, in order, marking the final one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cns_result_buf import cns_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  run_t                run,
  input  cell_result_t        res [RES_N],
  output logic                free,
  cns_stream_if.source        result
);

  logic [RES_N-1:0] pending;
  logic [RES_N-1:0] first;
  logic             last;
  logic             send;
  cell_result_t     held [RES_N];
  cell_result_t     pick;

  assign first = pending & RES_N'(~pending + 1'b1);
  assign last  = (pending & ~first) == '0;
  assign send  = result.valid && result.ready;
  assign free  = (pending == '0) || (send && last);

  always_comb begin
    pick = held[0];
    for (int i = RES_N - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick = held[i];
      end
    end
  end

  assign result.valid = |pending;
  assign result.data  = '{neighbour_sum: pick.sum, cell_row: pick.row,
                          cell_column: pick.column, last_of_run: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (run.load && free) begin
      pending <= run.mask;
    end else if (send) begin
      pending <= pending & ~first;
    end
  end

  always_ff @(posedge clk) begin
    if (run.load && free) begin
      held <= res;
    end
  end

endmodule

// ===== design/cross_neighbour_sum_stencil.sv =====
// ----------------------------------------------------------------------------
// cross_neighbour_sum_stencil
// Takes signed 16-bit samples of a grid in raster order and returns, for each
// cell, the sum of the cell and its in-grid up, down, left and right
// neighbours, tagged with its row and column. The word at (r,c) releases cell
// (r-1,c); on the last row it also releases (r,c-1), and the last word of the
// frame releases (r,c) too. Samples of all rows but the last, and the first
// word of the last row, are taken one word per cycle unless the result port
// stalls; after any other last-row word the input waits while the single
// result port drains its results one at a time. A released result is summed
// from stage 1 and held in the result buffer until taken. A write to
// row_count or column_count restarts the frame at row 0, column 0; sizes
// below 2 act as 2 and sizes above the maximum act as the maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cross_neighbour_sum_stencil import cns_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  cns_stream_if.sink             grid,
  cns_stream_if.source           result
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int DEPTH = 3 * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RCW   = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
  localparam int CCW   = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  function automatic logic [AW-1:0] addr_of(slot_t s, logic [CW-1:0] col);
    logic [AW-1:0] base;
    unique case (s)
      2'd1:    base = AW'(MAX_COLUMNS);
      2'd2:    base = AW'(2 * MAX_COLUMNS);
      default: base = '0;
    endcase
    return base + AW'(col);
  endfunction

  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] column_count;
  logic [RCW-1:0]   rows_eff;
  logic [CCW-1:0]   cols_eff;
  logic [RW-1:0]    rows_m1;
  logic [CW-1:0]    cols_m1;

  logic [RW-1:0]    row;
  logic [CW-1:0]    column;
  slot_t            slot;

  logic             accept;
  logic             buf_free;
  logic             advance;
  step_flags_t      flags;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr0;
  logic [AW-1:0]    raddr1;
  sample_t          rdata0;
  sample_t          rdata1;

  sample_t          prev1;
  sample_t          prev2;

  logic             s1_valid;
  sample_t          s1_sample;
  sample_t          s1_m1;
  sample_t          s1_m2;
  logic [RW-1:0]    s1_row;
  logic [CW-1:0]    s1_col;
  step_flags_t      s1_flags;

  sample_t          w_prev;
  sample_t          w_cur;

  sum_t             a_sum;
  sum_t             b_sum;
  sum_t             c_sum;
  cell_result_t     res [RES_N];
  run_t             run;

  // effective sizes
  always_comb begin
    rows_eff = RCW'(row_count);
    if (rows_eff < RCW'(2)) begin
      rows_eff = RCW'(2);
    end else if (rows_eff > RCW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end
    cols_eff = CCW'(column_count);
    if (cols_eff < CCW'(2)) begin
      cols_eff = CCW'(2);
    end else if (cols_eff > CCW'(MAX_COLUMNS)) begin
      cols_eff = CCW'(MAX_COLUMNS);
    end
  end

  assign rows_m1 = RW'(rows_eff - 1'b1);
  assign cols_m1 = CW'(cols_eff - 1'b1);

  assign grid.ready = !s1_valid || buf_free;
  assign accept     = grid.valid && grid.ready;
  assign advance    = s1_valid && buf_free;

  always_comb begin
    flags.release_up = row != '0;
    flags.has_up     = row > RW'(1);
    flags.last_row   = row == rows_m1;
    flags.has_left   = column != '0;
    flags.has_left2  = column > CW'(1);
    flags.last_col   = column == cols_m1;
    flags.has_right  = !flags.last_col;
  end

  // port 0 fetches the right neighbour of the row above, or at the end of a
  // row the first entry of this row for the next row's window
  assign waddr  = addr_of(slot, column);
  assign raddr0 = flags.last_col ? addr_of(slot, '0)
                                 : addr_of(slot_back1(slot), CW'(column + 1'b1));
  assign raddr1 = addr_of(slot_back2(slot), column);

  cns_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk    (clk),
    .we     (accept),
    .waddr  (waddr),
    .wdata  (grid.data.sample),
    .re     (accept),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RST;
      column_count <= COLUMN_COUNT_RST;
      row          <= '0;
      column       <= '0;
      slot         <= '0;
    end else if (cfg_write &&
                 (cfg_index == REG_ROW_COUNT || cfg_index == REG_COLUMN_COUNT)) begin
      if (cfg_index == REG_ROW_COUNT) begin
        row_count <= cfg_data;
      end else begin
        column_count <= cfg_data;
      end
      row    <= '0;
      column <= '0;
      slot   <= '0;
    end else if (accept) begin
      if (flags.last_col) begin
        column <= '0;
        if (flags.last_row) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= RW'(row + 1'b1);
          slot <= (slot == 2'd2) ? 2'd0 : slot_t'(slot + 2'd1);
        end
      end else begin
        column <= CW'(column + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev1     <= grid.data.sample;
      prev2     <= prev1;
      s1_sample <= grid.data.sample;
      s1_m1     <= prev1;
      s1_m2     <= prev2;
      s1_row    <= row;
      s1_col    <= column;
      s1_flags  <= flags;
    end
    if (advance) begin
      w_prev <= w_cur;
      w_cur  <= rdata0;
    end
  end

  // stencil sums of the cells released by the word in stage 1
  always_comb begin
    a_sum = sext(s1_sample) + sext(w_cur)
          + (s1_flags.has_up    ? sext(rdata1) : '0)
          + (s1_flags.has_left  ? sext(w_prev) : '0)
          + (s1_flags.has_right ? sext(rdata0) : '0);
    b_sum = sext(s1_m1) + sext(w_prev) + sext(s1_sample)
          + (s1_flags.has_left2 ? sext(s1_m2) : '0);
    c_sum = sext(s1_sample) + sext(w_cur) + sext(s1_m1);
  end

  assign res[0] = '{sum: a_sum, row: IDX_W'(RW'(s1_row - 1'b1)), column: IDX_W'(s1_col)};
  assign res[1] = '{sum: b_sum, row: IDX_W'(s1_row), column: IDX_W'(CW'(s1_col - 1'b1))};
  assign res[2] = '{sum: c_sum, row: IDX_W'(s1_row), column: IDX_W'(s1_col)};

  assign run.load = advance;
  assign run.mask = {s1_flags.last_row && s1_flags.last_col,
                     s1_flags.last_row && s1_flags.has_left,
                     s1_flags.release_up};

  cns_result_buf u_buf (
    .clk    (clk),
    .rst    (rst),
    .run    (run),
    .res    (res),
    .free   (buf_free),
    .result (result)
  );

endmodule

// ===== design/cns_checker.sv =====
// ----------------------------------------------------------------------------
// cns_checker
// Port-level checks of the stencil sum block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cns_checker import cns_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         grid_ready,
  input logic         result_valid,
  input logic         result_ready,
  input result_word_t result_data
);

  // stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result valid dropped while stalled");

  // stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_data))
    else $error("result word changed while stalled");

  // a run continues until its last word
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready && !result_data.last_of_run |=> result_valid)
    else $error("run ended without last_of_run");

  // nothing waiting means input is open
  assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> grid_ready)
    else $error("input blocked with no result waiting");

  // reset empties the block
  assert property (@(posedge clk)
    rst |=> !result_valid && grid_ready)
    else $error("block not empty after reset");

endmodule

bind cross_neighbour_sum_stencil cns_checker u_cns_checker (
  .clk          (clk),
  .rst          (rst),
  .grid_ready   (grid.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_data  (result.data)
);
